/* hdl/tts_pkg.sv */
// Shared types and constants of the timed task scheduler.
package tts_pkg;

  // Fixed field widths of the stream words
  localparam int unsigned OP_BITS       = 2;
  localparam int unsigned SLOT_BITS     = 4;
  localparam int unsigned FIELD_BITS    = 32;
  localparam int unsigned STATUS_BITS   = 2;
  localparam int unsigned FIRE_CNT_BITS = 6;
  localparam int unsigned IN_DATA_BITS  = 136;
  localparam int unsigned OUT_DATA_BITS = 40;

  // Input op codes
  localparam logic [OP_BITS-1:0] OP_CHECK    = 2'd0;
  localparam logic [OP_BITS-1:0] OP_PERIODIC = 2'd1;
  localparam logic [OP_BITS-1:0] OP_ONESHOT  = 2'd2;
  localparam logic [OP_BITS-1:0] OP_CANCEL   = 2'd3;

  // Result status codes
  localparam logic [STATUS_BITS-1:0] ST_OK       = 2'd0;
  localparam logic [STATUS_BITS-1:0] ST_BUSY     = 2'd1;
  localparam logic [STATUS_BITS-1:0] ST_EMPTY    = 2'd2;
  localparam logic [STATUS_BITS-1:0] ST_NO_TASKS = 2'd3;

  typedef enum logic {
    ALU_ADD,
    ALU_SUB
  } tts_alu_op_e;

  typedef struct packed {
    logic borrow;
    logic zero;
  } tts_alu_flags_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_CMD,
    S_SCAN,
    S_DECIDE,
    S_ADV,
    S_EMIT
  } tts_state_e;

endpackage

/* hdl/tts_ram.sv */
// Generic single-write, single-read RAM with registered read data.
module tts_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

/* hdl/tts_alu.sv */
// Shared add/subtract unit with borrow and zero flags.
module tts_alu
  import tts_pkg::*;
#(
  parameter int unsigned WIDTH = 32
) (
  input  tts_alu_op_e    op_i,
  input  logic [WIDTH-1:0] a_i,
  input  logic [WIDTH-1:0] b_i,
  output logic [WIDTH-1:0] res_o,
  output tts_alu_flags_t   flags_o
);

  logic [WIDTH:0] sum;

  always_comb begin
    unique case (op_i)
      ALU_ADD: sum = {1'b0, a_i} + {1'b0, b_i};
      ALU_SUB: sum = {1'b0, a_i} - {1'b0, b_i};
      default: sum = '0;
    endcase
  end

  assign res_o          = sum[WIDTH-1:0];
  // borrow is a < b on subtract, carry out on add
  assign flags_o.borrow = sum[WIDTH];
  assign flags_o.zero   = (sum[WIDTH-1:0] == '0);

endmodule

/* hdl/timed_task_scheduler.sv */
// Timed task scheduler: timer slot table with a sequential earliest-due search.
//
// Start and cancel words pass through accept, update and result states. A
// check word rescans the slot table once per fire and once for its final
// result: each scan reads the due-time RAM through the shared compare unit,
// then takes a decision state and a result state, with a period add state
// between the two for a periodic fire; a result can also wait on
// m_axis_tready_i. No new word is accepted until the final result of a word
// is taken into the output register.
// The output register lets a new word in while the last result still waits.
// Input tuser carries op; output tuser carries is_fire, tlast marks the final
// result of a word. No reset sweep: slot valid bits clear at reset.
module timed_task_scheduler
  import tts_pkg::*;
#(
  parameter int unsigned NUM_SLOTS  = 16,
  parameter int unsigned CLOCK_BITS = 32,
  parameter int unsigned MAX_FIRES  = 63
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     s_axis_tvalid_i,
  output logic                     s_axis_tready_o,
  // slot[3:0], now[35:4], initial_wait[67:36], period[99:68], run_at[131:100]
  input  logic [IN_DATA_BITS-1:0]  s_axis_tdata_i,
  // op[1:0]
  input  logic [OP_BITS-1:0]       s_axis_tuser_i,
  output logic                     m_axis_tvalid_o,
  input  logic                     m_axis_tready_i,
  // fired_slot[3:0], clocks_left[35:4], activity[36], more_pending[37], status[39:38]
  output logic [OUT_DATA_BITS-1:0] m_axis_tdata_o,
  // is_fire[0]
  output logic                     m_axis_tuser_o,
  output logic                     m_axis_tlast_o
);

  localparam int unsigned SW = $clog2(NUM_SLOTS);
  localparam int unsigned IW = $clog2(NUM_SLOTS + 1);
  localparam int unsigned CB = CLOCK_BITS;
  localparam logic [63:0] MAX_LEFT = 64'h0000_0000_FFFF_FFFF;

  tts_state_e state_q, state_d;

  // latched input word
  logic [OP_BITS-1:0]    op_q;
  logic [SLOT_BITS-1:0]  slot_q;
  logic [CB-1:0]         now_q;
  logic [FIELD_BITS-1:0] wait_q, per_q, at_q;

  logic [NUM_SLOTS-1:0]  valid_q, valid_d;
  logic [NUM_SLOTS-1:0]  periodic_q, periodic_d;

  // scan state
  logic [IW-1:0]            idx_q, idx_d;
  logic                     pend_q, pend_d;
  logic [SW-1:0]            pidx_q, pidx_d;
  logic                     found_q, found_d;
  logic [SW-1:0]            best_q, best_d;
  logic [CB-1:0]            best_due_q, best_due_d;
  logic [FIRE_CNT_BITS-1:0] fires_q, fires_d;

  // staged result
  logic                   r_fire_q, r_fire_d;
  logic [SLOT_BITS-1:0]   r_slot_q, r_slot_d;
  logic [FIELD_BITS-1:0]  r_left_q, r_left_d;
  logic                   r_act_q, r_act_d;
  logic                   r_more_q, r_more_d;
  logic [STATUS_BITS-1:0] r_status_q, r_status_d;
  logic                   r_last_q, r_last_d;

  logic                     m_valid_q, m_valid_d;
  logic [OUT_DATA_BITS-1:0] m_data_q, m_data_d;
  logic                     m_user_q, m_user_d;
  logic                     m_last_q, m_last_d;

  // RAM ports
  logic          due_we, per_we;
  logic [SW-1:0] due_waddr, due_raddr;
  logic [CB-1:0] due_wdata, due_rdata, per_rdata;

  // shared unit
  tts_alu_op_e    alu_op;
  logic [CB-1:0]  alu_a, alu_b, alu_res;
  tts_alu_flags_t alu_flags;

  logic          in_acc, out_free, inrange, slot_busy, scan_done;
  logic          due_later, limit_hit, fire_go;
  logic [SW-1:0] sidx;

  assign in_acc    = s_axis_tvalid_i && s_axis_tready_o;
  assign out_free  = !m_valid_q || m_axis_tready_i;
  assign inrange   = int'(slot_q) < NUM_SLOTS;
  assign sidx      = SW'(slot_q);
  assign slot_busy = inrange && valid_q[sidx];
  assign scan_done = (idx_q == IW'(NUM_SLOTS)) && !pend_q;
  // in the decision cycle the unit computes best_due - now
  assign due_later = !alu_flags.borrow && !alu_flags.zero;
  assign limit_hit = fires_q >= FIRE_CNT_BITS'(MAX_FIRES);
  assign fire_go   = found_q && !due_later && !limit_hit;

  tts_ram #(.WIDTH(CB), .DEPTH(NUM_SLOTS)) u_due_ram (
    .clk_i  (clk_i),
    .we_i   (due_we),
    .waddr_i(due_waddr),
    .wdata_i(due_wdata),
    .raddr_i(due_raddr),
    .rdata_o(due_rdata)
  );

  tts_ram #(.WIDTH(CB), .DEPTH(NUM_SLOTS)) u_per_ram (
    .clk_i  (clk_i),
    .we_i   (per_we),
    .waddr_i(sidx),
    .wdata_i(CB'(per_q)),
    .raddr_i(best_q),
    .rdata_o(per_rdata)
  );

  tts_alu #(.WIDTH(CB)) u_alu (
    .op_i   (alu_op),
    .a_i    (alu_a),
    .b_i    (alu_b),
    .res_o  (alu_res),
    .flags_o(alu_flags)
  );

  // shared unit operand select
  always_comb begin
    alu_op = ALU_SUB;
    alu_a  = '0;
    alu_b  = '0;
    unique case (state_q)
      S_SCAN: begin
        alu_a = due_rdata;
        alu_b = best_due_q;
      end
      S_DECIDE: begin
        alu_a = best_due_q;
        alu_b = now_q;
      end
      S_ADV: begin
        alu_op = ALU_ADD;
        alu_a  = best_due_q;
        alu_b  = per_rdata;
      end
      S_CMD: begin
        alu_op = ALU_ADD;
        alu_a  = now_q;
        alu_b  = CB'(wait_q);
      end
      default: begin
        alu_op = ALU_SUB;
      end
    endcase
  end

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          state_d = (s_axis_tuser_i == OP_CHECK) ? S_SCAN : S_CMD;
        end
      end
      S_CMD:  state_d = S_EMIT;
      S_SCAN: begin
        if (scan_done) begin
          state_d = S_DECIDE;
        end
      end
      S_DECIDE: begin
        state_d = (fire_go && periodic_q[best_q]) ? S_ADV : S_EMIT;
      end
      S_ADV:  state_d = S_EMIT;
      S_EMIT: begin
        if (out_free) begin
          state_d = r_last_q ? S_IDLE : S_SCAN;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // datapath and outputs
  always_comb begin
    valid_d    = valid_q;
    periodic_d = periodic_q;
    idx_d      = idx_q;
    pend_d     = pend_q;
    pidx_d     = pidx_q;
    found_d    = found_q;
    best_d     = best_q;
    best_due_d = best_due_q;
    fires_d    = fires_q;
    r_fire_d   = r_fire_q;
    r_slot_d   = r_slot_q;
    r_left_d   = r_left_q;
    r_act_d    = r_act_q;
    r_more_d   = r_more_q;
    r_status_d = r_status_q;
    r_last_d   = r_last_q;
    m_valid_d  = m_valid_q && !m_axis_tready_i;
    m_data_d   = m_data_q;
    m_user_d   = m_user_q;
    m_last_d   = m_last_q;
    due_we     = 1'b0;
    due_waddr  = sidx;
    due_wdata  = alu_res;
    due_raddr  = SW'(idx_q);
    per_we     = 1'b0;

    s_axis_tready_o = (state_q == S_IDLE);

    unique case (state_q)
      S_IDLE: begin
        idx_d   = '0;
        pend_d  = 1'b0;
        found_d = 1'b0;
        fires_d = '0;
      end
      S_CMD: begin
        r_fire_d   = 1'b0;
        r_slot_d   = '0;
        r_left_d   = '0;
        r_act_d    = 1'b0;
        r_more_d   = 1'b0;
        r_last_d   = 1'b1;
        r_status_d = ST_OK;
        if (op_q == OP_CANCEL) begin
          if (!slot_busy) begin
            r_status_d = ST_EMPTY;
          end else begin
            valid_d[sidx] = 1'b0;
          end
        end else if (!inrange || slot_busy) begin
          r_status_d = ST_BUSY;
        end else begin
          valid_d[sidx]    = 1'b1;
          periodic_d[sidx] = (op_q == OP_PERIODIC);
          due_we           = 1'b1;
          due_wdata        = (op_q == OP_PERIODIC) ? alu_res : CB'(at_q);
          per_we           = (op_q == OP_PERIODIC);
        end
      end
      S_SCAN: begin
        // strict less keeps the lowest slot on ties
        if (pend_q && valid_q[pidx_q] && (!found_q || alu_flags.borrow)) begin
          found_d    = 1'b1;
          best_d     = pidx_q;
          best_due_d = due_rdata;
        end
        if (idx_q < IW'(NUM_SLOTS)) begin
          pend_d = 1'b1;
          pidx_d = SW'(idx_q);
          idx_d  = idx_q + IW'(1);
        end else begin
          pend_d = 1'b0;
        end
      end
      S_DECIDE: begin
        r_fire_d   = 1'b0;
        r_slot_d   = '0;
        r_left_d   = '0;
        r_act_d    = (fires_q != '0);
        r_more_d   = 1'b0;
        r_status_d = ST_OK;
        r_last_d   = 1'b1;
        if (!found_q) begin
          r_status_d = ST_NO_TASKS;
        end else if (due_later) begin
          // saturate wide clocks to the 32-bit field
          if (64'(alu_res) > MAX_LEFT) begin
            r_left_d = '1;
          end else begin
            r_left_d = FIELD_BITS'(alu_res);
          end
        end else if (limit_hit) begin
          r_act_d  = 1'b1;
          r_more_d = 1'b1;
        end else begin
          r_fire_d = 1'b1;
          r_slot_d = SLOT_BITS'(best_q);
          r_act_d  = 1'b1;
          r_last_d = 1'b0;
          fires_d  = fires_q + FIRE_CNT_BITS'(1);
          if (!periodic_q[best_q]) begin
            valid_d[best_q] = 1'b0;
          end
        end
      end
      S_ADV: begin
        due_we    = 1'b1;
        due_waddr = best_q;
        due_wdata = alu_res;
      end
      S_EMIT: begin
        idx_d   = '0;
        pend_d  = 1'b0;
        found_d = 1'b0;
        if (out_free) begin
          m_valid_d = 1'b1;
          m_data_d  = {r_status_q, r_more_q, r_act_q, r_left_q, r_slot_q};
          m_user_d  = r_fire_q;
          m_last_d  = r_last_q;
        end
      end
      default: begin
        idx_d = '0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_IDLE;
      valid_q    <= '0;
      periodic_q <= '0;
      idx_q      <= '0;
      pend_q     <= 1'b0;
      found_q    <= 1'b0;
      fires_q    <= '0;
      m_valid_q  <= 1'b0;
    end else begin
      state_q    <= state_d;
      valid_q    <= valid_d;
      periodic_q <= periodic_d;
      idx_q      <= idx_d;
      pend_q     <= pend_d;
      found_q    <= found_d;
      fires_q    <= fires_d;
      m_valid_q  <= m_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      op_q   <= s_axis_tuser_i;
      slot_q <= s_axis_tdata_i[3:0];
      now_q  <= CB'(s_axis_tdata_i[35:4]);
      wait_q <= s_axis_tdata_i[67:36];
      per_q  <= s_axis_tdata_i[99:68];
      at_q   <= s_axis_tdata_i[131:100];
    end
    pidx_q     <= pidx_d;
    best_q     <= best_d;
    best_due_q <= best_due_d;
    r_fire_q   <= r_fire_d;
    r_slot_q   <= r_slot_d;
    r_left_q   <= r_left_d;
    r_act_q    <= r_act_d;
    r_more_q   <= r_more_d;
    r_status_q <= r_status_d;
    r_last_q   <= r_last_d;
    m_data_q   <= m_data_d;
    m_user_q   <= m_user_d;
    m_last_q   <= m_last_d;
  end

  assign m_axis_tvalid_o = m_valid_q;
  assign m_axis_tdata_o  = m_data_q;
  assign m_axis_tuser_o  = m_user_q;
  assign m_axis_tlast_o  = m_last_q;

  a_fire_limit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fires_q <= FIRE_CNT_BITS'(MAX_FIRES))
    else $error("fire count passed the limit");

  a_fire_not_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && m_axis_tuser_o) |-> !m_axis_tlast_o)
    else $error("fire word marked last");

  a_emit_loads: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_EMIT && out_free) |=> m_axis_tvalid_o)
    else $error("staged result not presented");

  a_adv_periodic: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_ADV) |-> (valid_q[best_q] && periodic_q[best_q]))
    else $error("period advance on a slot that is not periodic");

endmodule
